### design/scld_pkg.sv
package scld_pkg;

  localparam logic [7:0] ZeroSubstReset = 8'd254;
  localparam logic signed [16:0] XMinReset = 17'sd256;
  localparam logic [16:0] ShortLineLimit = 17'd3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_SPRITE = 2'd2
  } kind_e;

  typedef enum logic [10:0] {
    PH_H0       = 11'b000_0000_0001,
    PH_H1       = 11'b000_0000_0010,
    PH_Y0       = 11'b000_0000_0100,
    PH_Y1       = 11'b000_0000_1000,
    PH_L0       = 11'b000_0001_0000,
    PH_L1       = 11'b000_0010_0000,
    PH_FUL      = 11'b000_0100_0000,
    PH_PAR      = 11'b000_1000_0000,
    PH_FULLDATA = 11'b001_0000_0000,
    PH_PARTPIX  = 11'b010_0000_0000,
    PH_PARTMASK = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic               has_pixel;
    logic               has_line;
    logic               has_sprite;
  } rec_mask_t;

  typedef struct packed {
    rec_mask_t          mask;
    logic [7:0]         pixel_value;
    logic [10:0]        pixel_index;
    logic signed [15:0] line_offset;
    logic [10:0]        line_length;
    logic signed [15:0] x_min;
    logic signed [16:0] x_max;
    logic [15:0]        height;
    logic signed [15:0] yofs;
    logic [15:0]        lines;
    logic               truncated;
  } step_t;

endpackage

### design/scld_decode.sv
module scld_decode import scld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  data_byte_i,
  input  logic [16:0] bytes_after_i,
  input  logic [7:0]  zero_subst_i,
  output step_t       step_o
);

  phase_e             phase_q, phase_d;
  logic [7:0]         lowhold_q, lowhold_d;
  logic [15:0]        height_q, height_d;
  logic [15:0]        yoff_q, yoff_d;
  logic [15:0]        linecnt_q, linecnt_d;
  logic [15:0]        curoff_q, curoff_d;
  logic [7:0]         full_q, full_d;
  logic [7:0]         partial_q, partial_d;
  logic [10:0]        bytecnt_q, bytecnt_d;
  logic [1:0]         chunkpos_q, chunkpos_d;
  logic [10:0]        trim_q, trim_d;
  logic signed [16:0] xmin_q, xmin_d;
  logic signed [16:0] xmax_q, xmax_d;
  logic               stopped_q, stopped_d;
  logic [7:0]         pixels_q [4];

  logic               do_line;
  logic               spr;
  logic               trunc;
  logic signed [16:0] off_ext;
  logic signed [16:0] line_end;
  logic [7:0]         stored_pix;

  assign off_ext    = $signed({curoff_q[15], curoff_q});
  assign stored_pix = pixels_q[chunkpos_q];

  always_comb begin
    phase_d    = phase_q;
    lowhold_d  = lowhold_q;
    height_d   = height_q;
    yoff_d     = yoff_q;
    linecnt_d  = linecnt_q;
    curoff_d   = curoff_q;
    full_d     = full_q;
    partial_d  = partial_q;
    bytecnt_d  = bytecnt_q;
    chunkpos_d = chunkpos_q;
    trim_d     = trim_q;
    xmin_d     = xmin_q;
    xmax_d     = xmax_q;
    stopped_d  = stopped_q;
    do_line    = 1'b0;
    spr        = 1'b0;
    trunc      = 1'b0;
    line_end   = '0;
    step_o     = '0;

    if (!stopped_q) begin
      unique case (phase_q)
        PH_H0: begin
          linecnt_d = '0;
          xmin_d    = XMinReset;
          xmax_d    = '0;
          height_d  = {8'd0, data_byte_i};
          yoff_d    = '0;
          lowhold_d = data_byte_i;
          phase_d   = PH_H1;
        end
        PH_H1: begin
          height_d = {data_byte_i, lowhold_q};
          phase_d  = PH_Y0;
        end
        PH_Y0: begin
          lowhold_d = data_byte_i;
          yoff_d    = {8'd0, data_byte_i};
          phase_d   = PH_Y1;
        end
        PH_Y1: begin
          yoff_d  = {data_byte_i, lowhold_q};
          phase_d = PH_L0;
          if (height_q == '0) begin
            spr = 1'b1;
          end
        end
        PH_L0: begin
          if (bytes_after_i <= ShortLineLimit) begin
            spr   = 1'b1;
            trunc = 1'b1;
          end else begin
            lowhold_d = data_byte_i;
            phase_d   = PH_L1;
          end
        end
        PH_L1: begin
          curoff_d = {data_byte_i, lowhold_q};
          phase_d  = PH_FUL;
        end
        PH_FUL: begin
          full_d  = data_byte_i;
          phase_d = PH_PAR;
        end
        PH_PAR: begin
          partial_d  = data_byte_i;
          bytecnt_d  = '0;
          trim_d     = '0;
          chunkpos_d = '0;
          if ((full_q != '0 || data_byte_i != '0) && off_ext < xmin_q) begin
            xmin_d = off_ext;
          end
          if (full_q != '0) begin
            phase_d = PH_FULLDATA;
          end else if (data_byte_i != '0) begin
            phase_d = PH_PARTPIX;
          end else begin
            do_line = 1'b1;
          end
        end
        PH_FULLDATA: begin
          step_o.mask.has_pixel = 1'b1;
          step_o.pixel_value    = (data_byte_i != '0) ? data_byte_i : zero_subst_i;
          step_o.pixel_index    = bytecnt_q;
          bytecnt_d             = bytecnt_q + 11'd1;
          trim_d                = bytecnt_d;
          if (bytecnt_d >= {1'b0, full_q, 2'b00}) begin
            chunkpos_d = '0;
            if (partial_q != '0) begin
              phase_d = PH_PARTPIX;
            end else begin
              do_line = 1'b1;
            end
          end
        end
        PH_PARTPIX: begin
          chunkpos_d = chunkpos_q + 2'd1;
          if (chunkpos_q == 2'd3) begin
            phase_d = PH_PARTMASK;
          end
        end
        PH_PARTMASK: begin
          step_o.mask.has_pixel = 1'b1;
          step_o.pixel_index    = bytecnt_q;
          bytecnt_d             = bytecnt_q + 11'd1;
          if (data_byte_i != '0) begin
            step_o.pixel_value = '0;
          end else begin
            step_o.pixel_value = (stored_pix != '0) ? stored_pix : zero_subst_i;
            trim_d             = bytecnt_d;
          end
          chunkpos_d = chunkpos_q + 2'd1;
          if (chunkpos_q == 2'd3) begin
            partial_d = partial_q - 8'd1;
            if (partial_d == '0) begin
              do_line = 1'b1;
            end else begin
              phase_d = PH_PARTPIX;
            end
          end
        end
        default: begin
          phase_d = PH_H0;
        end
      endcase

      if (do_line) begin
        line_end             = off_ext + $signed({6'd0, trim_d});
        step_o.mask.has_line = 1'b1;
        step_o.line_offset   = $signed(curoff_q);
        step_o.line_length   = trim_d;
        if (line_end > xmax_q) begin
          xmax_d = line_end;
        end
        linecnt_d = linecnt_q + 16'd1;
        phase_d   = PH_L0;
        if (linecnt_d == height_q) begin
          spr = 1'b1;
        end
      end

      if (spr) begin
        stopped_d = 1'b1;
      end
    end

    if (bytes_after_i == '0) begin
      if (!stopped_d) begin
        spr   = 1'b1;
        trunc = 1'b1;
      end
      stopped_d = 1'b0;
      phase_d   = PH_H0;
    end

    if (spr) begin
      step_o.mask.has_sprite = 1'b1;
      step_o.x_min           = xmin_d[15:0];
      step_o.x_max           = xmax_d;
      step_o.height          = height_d;
      step_o.yofs            = $signed(yoff_d);
      step_o.lines           = linecnt_d;
      step_o.truncated       = trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_H0;
      lowhold_q  <= '0;
      height_q   <= '0;
      yoff_q     <= '0;
      linecnt_q  <= '0;
      curoff_q   <= '0;
      full_q     <= '0;
      partial_q  <= '0;
      bytecnt_q  <= '0;
      chunkpos_q <= '0;
      trim_q     <= '0;
      xmin_q     <= XMinReset;
      xmax_q     <= '0;
      stopped_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      lowhold_q  <= lowhold_d;
      height_q   <= height_d;
      yoff_q     <= yoff_d;
      linecnt_q  <= linecnt_d;
      curoff_q   <= curoff_d;
      full_q     <= full_d;
      partial_q  <= partial_d;
      bytecnt_q  <= bytecnt_d;
      chunkpos_q <= chunkpos_d;
      trim_q     <= trim_d;
      xmin_q     <= xmin_d;
      xmax_q     <= xmax_d;
      stopped_q  <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !stopped_q && phase_q == PH_PARTPIX) begin
      pixels_q[chunkpos_q] <= data_byte_i;
    end
  end

endmodule

### design/scld_out_queue.sv
module scld_out_queue import scld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  step_t              step_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         pixel_value_o,
  output logic [10:0]        pixel_index_o,
  output logic signed [15:0] line_offset_o,
  output logic [10:0]        line_length_o,
  output logic signed [15:0] sprite_x_min_o,
  output logic signed [16:0] sprite_x_max_o,
  output logic [15:0]        sprite_height_o,
  output logic signed [15:0] sprite_y_offset_o,
  output logic [15:0]        lines_decoded_o,
  output logic               truncated_o,
  output logic               last_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  step_t           slots_q [QueueDepth];
  logic [2:0]      mask_q  [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  step_t      head;
  logic [2:0] head_mask;
  logic [2:0] low_bit;
  logic [2:0] rest_mask;
  logic       pop;
  logic       retire;
  kind_e      kind;

  assign head      = slots_q[rd_ptr_q];
  assign head_mask = mask_q[rd_ptr_q];
  assign low_bit   = head_mask & (~head_mask + 3'd1);
  assign rest_mask = head_mask & ~low_bit;

  assign out_valid_o = (count_q != '0);
  assign full_o      = (count_q == CntW'(QueueDepth));
  assign pop         = out_valid_o && !out_stall_i;
  assign retire      = pop && (rest_mask == '0);
  assign last_o      = out_valid_o && (rest_mask == '0);

  always_comb begin
    if (head_mask[0]) begin
      kind = KIND_PIXEL;
    end else if (head_mask[1]) begin
      kind = KIND_LINE;
    end else begin
      kind = KIND_SPRITE;
    end
  end

  assign kind_o            = kind;
  assign pixel_value_o     = (kind == KIND_PIXEL)  ? head.pixel_value : '0;
  assign pixel_index_o     = (kind == KIND_PIXEL)  ? head.pixel_index : '0;
  assign line_offset_o     = (kind == KIND_LINE)   ? head.line_offset : '0;
  assign line_length_o     = (kind == KIND_LINE)   ? head.line_length : '0;
  assign sprite_x_min_o    = (kind == KIND_SPRITE) ? head.x_min       : '0;
  assign sprite_x_max_o    = (kind == KIND_SPRITE) ? head.x_max       : '0;
  assign sprite_height_o   = (kind == KIND_SPRITE) ? head.height      : '0;
  assign sprite_y_offset_o = (kind == KIND_SPRITE) ? head.yofs        : '0;
  assign lines_decoded_o   = (kind == KIND_SPRITE) ? head.lines       : '0;
  assign truncated_o       = (kind == KIND_SPRITE) ? head.truncated   : 1'b0;

  always_comb begin
    count_d = count_q;
    if (push_i && !retire) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && retire) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      for (int i = 0; i < QueueDepth; i++) begin
        mask_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      if (pop) begin
        mask_q[rd_ptr_q] <= rest_mask;
      end
      if (retire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i) begin
        mask_q[wr_ptr_q] <= {step_i.mask.has_sprite, step_i.mask.has_line,
                             step_i.mask.has_pixel};
        wr_ptr_q         <= wr_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= step_i;
    end
  end

endmodule

### design/sprite_chunk_line_decoder_unit.sv
// Sprite chunk line decoder.
// Input channel: one stream word per accepted handshake (in_valid_i high, in_stall_o
// low): data_byte_i plus bytes_after_i, the count of words still to come (0 on the
// final word). Output channel: one record per handshake (out_valid_o high,
// out_stall_i low); kind_o selects pixel, line or sprite record, unused fields are
// 0, last_o marks the final record caused by one input word.
// Config: cfg_we_i writes cfg_wdata_i into the zero substitute colour; write only
// while no word is in flight.
// Path: a word is registered, then decoded once the record queue has room; its
// records are written into the queue, whose head drives the output.
// Throughput: one word per cycle while out_stall_i is low and each word yields at
// most one record; a word yielding two or three records holds the output until each
// is taken. The limit is the single output port fed from a two-entry record queue.
// Reset: decoder waits for a sprite header, queue empty, colour back to 254.
// Stall: when out_stall_i holds, the queue fills and in_stall_o rises; no word or
// record is lost, and out_valid_o with its fields holds until taken.
module sprite_chunk_line_decoder_unit import scld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic [16:0]        bytes_after_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         pixel_value_o,
  output logic [10:0]        pixel_index_o,
  output logic signed [15:0] line_offset_o,
  output logic [10:0]        line_length_o,
  output logic signed [15:0] sprite_x_min_o,
  output logic signed [16:0] sprite_x_max_o,
  output logic [15:0]        sprite_height_o,
  output logic signed [15:0] sprite_y_offset_o,
  output logic [15:0]        lines_decoded_o,
  output logic               truncated_o,
  output logic               last_o
);

  logic        in_valid_q;
  logic [7:0]  data_q;
  logic [16:0] after_q;
  logic [7:0]  zsub_q;
  logic        queue_full;
  logic        fire;
  logic        push;
  step_t       step;

  assign fire       = in_valid_q && !queue_full;
  assign in_stall_o = in_valid_q && !fire;
  assign push       = fire && (step.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      zsub_q     <= ZeroSubstReset;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (cfg_we_i) begin
        zsub_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q  <= data_byte_i;
      after_q <= bytes_after_i;
    end
  end

  scld_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .data_byte_i   (data_q),
    .bytes_after_i (after_q),
    .zero_subst_i  (zsub_q),
    .step_o        (step)
  );

  scld_out_queue u_queue (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .step_i            (step),
    .full_o            (queue_full),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .pixel_value_o     (pixel_value_o),
    .pixel_index_o     (pixel_index_o),
    .line_offset_o     (line_offset_o),
    .line_length_o     (line_length_o),
    .sprite_x_min_o    (sprite_x_min_o),
    .sprite_x_max_o    (sprite_x_max_o),
    .sprite_height_o   (sprite_height_o),
    .sprite_y_offset_o (sprite_y_offset_o),
    .lines_decoded_o   (lines_decoded_o),
    .truncated_o       (truncated_o),
    .last_o            (last_o)
  );

endmodule
